@@ design/format_string_expander_unit_defines.svh @@
// Assertion helpers shared by the expander RTL.
// All checks are clocked on aclk and held off while aresetn is low.
`ifndef FORMAT_STRING_EXPANDER_UNIT_DEFINES_SVH
`define FORMAT_STRING_EXPANDER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FESX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FESX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/fesx_pkg.sv @@
package fesx_pkg;

    // Fixed field widths
    localparam int CHAR_W = 8;
    localparam int VAL_W  = 16;
    localparam int LEN_W  = 8;

    // BCD digits needed to hold any VAL_W-bit value
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Characters of interest
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
    localparam logic [CHAR_W-1:0] CH_B       = 8'h62;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;

    // Back-end operations
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_DEC  = 2'd2;
    localparam logic [1:0] OP_BIN  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] ch;
        logic [VAL_W-1:0]  value;
    } fesx_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fesx_qstat_t;

endpackage

@@ design/fesx_front.sv @@
module fesx_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fesx_pkg::CHAR_W-1:0]       s_in_char,
    input  logic [fesx_pkg::VAL_W-1:0]        s_value,
    input  fesx_pkg::fesx_qstat_t             q_stat,
    output logic                              q_push,
    output fesx_pkg::fesx_cmd_t               q_cmd
);
    import fesx_pkg::*;

    logic escape_reg;
    logic escape_next;
    logic has_cmd;
    logic accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // Classify the incoming character
    always_comb begin
        has_cmd     = 1'b0;
        escape_next = escape_reg;
        q_cmd.op    = OP_CHAR;
        q_cmd.ch    = s_in_char;
        q_cmd.value = s_value;
        if (escape_reg) begin
            escape_next = 1'b0;
            if (s_in_char == CH_NUL) begin
                has_cmd  = 1'b1;
                q_cmd.op = OP_END;
            end else if (s_in_char == CH_D) begin
                has_cmd  = 1'b1;
                q_cmd.op = OP_DEC;
            end else if (s_in_char == CH_B) begin
                has_cmd  = 1'b1;
                q_cmd.op = OP_BIN;
            end
        end else if (s_in_char == CH_NUL) begin
            has_cmd  = 1'b1;
            q_cmd.op = OP_END;
        end else if (s_in_char == CH_PERCENT) begin
            escape_next = 1'b1;
        end else begin
            has_cmd = 1'b1;
        end
    end

    assign q_push = accept && has_cmd;

    // Escape flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg <= 1'b0;
        end else if (accept) begin
            escape_reg <= escape_next;
        end
    end

endmodule

@@ design/fesx_queue.sv @@
module fesx_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  fesx_pkg::fesx_cmd_t   push_cmd,
    input  logic                  pop,
    output fesx_pkg::fesx_cmd_t   head_cmd,
    output fesx_pkg::fesx_qstat_t stat
);
    import fesx_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fesx_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    assign stat.full  = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/fesx_back.sv @@
module fesx_back #(
    parameter int DEC_DIGITS = 5,
    parameter int BIN_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fesx_pkg::fesx_qstat_t         q_stat,
    input  fesx_pkg::fesx_cmd_t           q_cmd,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fesx_pkg::CHAR_W-1:0]   m_out_char,
    output logic [fesx_pkg::LEN_W-1:0]    m_length,
    output logic                          m_done_res,
    output logic                          m_last
);
    import fesx_pkg::*;

    localparam int STEP_W = $clog2(VAL_W);
    localparam int DIDX_W = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
    localparam int BIDX_W = (BIN_BITS > 1) ? $clog2(BIN_BITS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_DEC  = 2'd2;
    localparam logic [1:0] ST_BIN  = 2'd3;

    logic [1:0]        state_reg,   state_next;
    logic [LEN_W-1:0]  count_reg,   count_next;
    logic [VAL_W-1:0]  sh_reg,      sh_next;
    logic [BCD_W-1:0]  bcd_reg,     bcd_next;
    logic [STEP_W-1:0] step_reg,    step_next;
    logic [DIDX_W-1:0] didx_reg,    didx_next;
    logic              started_reg, started_next;
    logic [BIDX_W-1:0] bidx_reg,    bidx_next;
    logic              valid_reg,   valid_next;
    logic [CHAR_W-1:0] char_reg,    char_next;
    logic [LEN_W-1:0]  len_reg,     len_next;
    logic              done_reg,    done_next;
    logic              last_reg,    last_next;

    logic              can_load;
    logic [BCD_W-1:0]  bcd_adj;
    logic [3:0]        digit;
    logic              show;
    logic              bin_bit;

    // Decimal digit at a position; positions past the converter read zero
    function automatic logic [3:0] digit_at(input logic [BCD_W-1:0] bcd,
                                            input logic [DIDX_W-1:0] idx);
        logic [3:0] d;
        d = 4'd0;
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if (int'(idx) == j) begin
                d = bcd[4*j +: 4];
            end
        end
        return d;
    endfunction

    // Value bit at a position; bits above the value width read zero
    function automatic logic bit_at(input logic [VAL_W-1:0] v,
                                    input logic [BIDX_W-1:0] idx);
        logic b;
        b = 1'b0;
        for (int j = 0; j < VAL_W; j++) begin
            if (int'(idx) == j) begin
                b = v[j];
            end
        end
        return b;
    endfunction

    // Add-3 correction for one shift-and-add BCD step
    always_comb begin
        for (int j = 0; j < BCD_DIGITS; j++) begin
            bcd_adj[4*j +: 4] = (bcd_reg[4*j +: 4] >= 4'd5) ? bcd_reg[4*j +: 4] + 4'd3
                                                             : bcd_reg[4*j +: 4];
        end
    end

    assign can_load = !valid_reg || m_ready;
    assign digit    = digit_at(bcd_reg, didx_reg);
    assign show     = (digit != 4'd0) || started_reg || (didx_reg == '0);
    assign bin_bit  = bit_at(sh_reg, bidx_reg);

    // Sequencer and output beat
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        sh_next      = sh_reg;
        bcd_next     = bcd_reg;
        step_next    = step_reg;
        didx_next    = didx_reg;
        started_next = started_reg;
        bidx_next    = bidx_reg;
        valid_next   = valid_reg && !m_ready;
        char_next    = char_reg;
        len_next     = len_reg;
        done_next    = done_reg;
        last_next    = last_reg;
        q_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    unique case (q_cmd.op)
                        OP_CHAR: begin
                            if (can_load) begin
                                q_pop      = 1'b1;
                                valid_next = 1'b1;
                                char_next  = q_cmd.ch;
                                len_next   = count_reg + 1'b1;
                                done_next  = 1'b0;
                                last_next  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_END: begin
                            if (can_load) begin
                                q_pop      = 1'b1;
                                valid_next = 1'b1;
                                char_next  = CH_NUL;
                                len_next   = count_reg;
                                done_next  = 1'b1;
                                last_next  = 1'b1;
                                count_next = '0;
                            end
                        end
                        OP_DEC: begin
                            q_pop      = 1'b1;
                            sh_next    = q_cmd.value;
                            bcd_next   = '0;
                            step_next  = STEP_W'(VAL_W - 1);
                            state_next = ST_CONV;
                        end
                        OP_BIN: begin
                            q_pop      = 1'b1;
                            sh_next    = q_cmd.value;
                            bidx_next  = BIDX_W'(BIN_BITS - 1);
                            state_next = ST_BIN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CONV: begin
                // one value bit per cycle, MSB first
                bcd_next  = {bcd_adj[BCD_W-2:0], sh_reg[VAL_W-1]};
                sh_next   = {sh_reg[VAL_W-2:0], 1'b0};
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    didx_next    = DIDX_W'(DEC_DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = ST_DEC;
                end
            end
            ST_DEC: begin
                // leading zeros are skipped without a beat
                if (!show || can_load) begin
                    if (show) begin
                        valid_next   = 1'b1;
                        char_next    = CH_ZERO + {{(CHAR_W-4){1'b0}}, digit};
                        len_next     = count_reg + 1'b1;
                        done_next    = 1'b0;
                        last_next    = (didx_reg == '0);
                        count_next   = count_reg + 1'b1;
                        started_next = 1'b1;
                    end
                    if (didx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        didx_next = didx_reg - 1'b1;
                    end
                end
            end
            ST_BIN: begin
                if (can_load) begin
                    valid_next = 1'b1;
                    char_next  = CH_ZERO + {{(CHAR_W-1){1'b0}}, bin_bit};
                    len_next   = count_reg + 1'b1;
                    done_next  = 1'b0;
                    last_next  = (bidx_reg == '0);
                    count_next = count_reg + 1'b1;
                    if (bidx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        bidx_next = bidx_reg - 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Datapath and output payload
    always_ff @(posedge aclk) begin
        sh_reg      <= sh_next;
        bcd_reg     <= bcd_next;
        step_reg    <= step_next;
        didx_reg    <= didx_next;
        started_reg <= started_next;
        bidx_reg    <= bidx_next;
        char_reg    <= char_next;
        len_reg     <= len_next;
        done_reg    <= done_next;
        last_reg    <= last_next;
    end

    assign m_valid    = valid_reg;
    assign m_out_char = char_reg;
    assign m_length   = len_reg;
    assign m_done_res = done_reg;
    assign m_last     = last_reg;

endmodule

@@ design/format_string_expander_unit.sv @@
// Format string expander.
// Input channel (s_valid/s_ready): one format character per beat on s_in_char,
// with the value for the percent-d and percent-b escapes on s_value.
// Result channel (m_valid/m_ready): one emitted character per beat on
// m_out_char with the running message length on m_length; m_last marks the
// final beat caused by one input, m_done_res marks the end-of-message beat
// (caused by a NUL) whose m_length is the final length modulo 256.
// A '%' and an unknown escape selector produce no beat.
// A literal or NUL beat passes through the queue entry register, then the output
// register, on its way to m_valid after its input beat is accepted.
// Literals and NULs sustain one beat per cycle while the receiver is ready. A
// percent-d is dispatched, converted in the bit-serial BCD converter, then
// emitted by walking the digits; a percent-b is dispatched, then emitted one bit
// per output beat. The back end takes no new command until the expansion is done.
// A two-entry command queue decouples the input side from the back end; when
// the receiver stalls the queue fills and s_ready drops.
// Reset clears the pending escape, the length count, the queue and m_valid.
`include "format_string_expander_unit_defines.svh"

module format_string_expander_unit #(
    parameter int DEC_DIGITS = 5,
    parameter int BIN_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fesx_pkg::CHAR_W-1:0]   s_in_char,
    input  logic [fesx_pkg::VAL_W-1:0]    s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fesx_pkg::CHAR_W-1:0]   m_out_char,
    output logic [fesx_pkg::LEN_W-1:0]    m_length,
    output logic                          m_done_res,
    output logic                          m_last
);
    import fesx_pkg::*;

    fesx_qstat_t q_stat;
    fesx_cmd_t   push_cmd;
    fesx_cmd_t   head_cmd;
    logic        q_push;
    logic        q_pop;

    // Front: accept and classify
    fesx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_char (s_in_char),
        .s_value   (s_value),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // Command queue
    fesx_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // Back: expand and emit
    fesx_back #(
        .DEC_DIGITS (DEC_DIGITS),
        .BIN_BITS   (BIN_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_length   (m_length),
        .m_done_res (m_done_res),
        .m_last     (m_last)
    );

    // Checks
    `FESX_ASSERT_IMP(a_done_is_last, m_valid && m_done_res, m_last && (m_out_char == CH_NUL), "done beat must be last and carry NUL")
    `FESX_ASSERT_IMP(a_char_nonzero, m_valid && !m_done_res, m_out_char != CH_NUL, "character beat carries NUL")
    `FESX_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "pop from empty command queue")
    `FESX_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full || q_pop, "push into full command queue")

endmodule

@@ test/format_string_expander_unit_test.sv @@
module format_string_expander_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fesx_pkg::*;

    localparam int DEC_DIGITS   = 5;
    localparam int BIN_BITS     = 16;
    localparam int RANDOM_BEATS = 350;

    // One expected beat on the result channel
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic [LEN_W-1:0]  length;
        logic              done_res;
        logic              last;
    } result_beat_t;

    // Tracks escape state and message length, and holds the beats still owed
    class expansion_checker;
        bit                escape_pending = 1'b0;
        bit [LEN_W-1:0]    emitted_count  = '0;
        result_beat_t      expected_beats[$];
        int                failures   = 0;
        int                checked    = 0;
        int                dec_count  = 0;
        int                bin_count  = 0;
        int                msg_count  = 0;
        int                wrap_count = 0;

        function void push_char(bit [CHAR_W-1:0] ch);
            result_beat_t b;
            if (emitted_count == '1) begin
                wrap_count++;
            end
            emitted_count = emitted_count + 1'b1;
            b = '{out_char: ch, length: emitted_count, done_res: 1'b0, last: 1'b0};
            expected_beats.push_back(b);
        endfunction

        function void push_end();
            result_beat_t b;
            b = '{out_char: CH_NUL, length: emitted_count, done_res: 1'b1, last: 1'b0};
            expected_beats.push_back(b);
            emitted_count = '0;
            msg_count++;
        endfunction

        // Low DEC_DIGITS decimal digits, leading zeros suppressed
        function void push_decimal(bit [VAL_W-1:0] val);
            longint unsigned scale = 1;
            longint unsigned v;
            longint unsigned digit;
            bit started = 1'b0;
            for (int i = 1; i < DEC_DIGITS; i++) begin
                scale *= 10;
            end
            v = val % (scale * 10);
            while (scale >= 1) begin
                digit = v / scale;
                if (digit != 0 || started || scale == 1) begin
                    started = 1'b1;
                    push_char(CH_ZERO + CHAR_W'(digit));
                end
                v -= digit * scale;
                scale /= 10;
            end
        endfunction

        function void push_binary(bit [VAL_W-1:0] val);
            for (int i = BIN_BITS - 1; i >= 0; i--) begin
                push_char(CH_ZERO + CHAR_W'(val[i]));
            end
        endfunction

        // Called for every accepted input beat
        function void take_format_char(bit [CHAR_W-1:0] ch, bit [VAL_W-1:0] val);
            int first;
            first = expected_beats.size();
            if (escape_pending) begin
                escape_pending = 1'b0;
                if (ch == CH_NUL) begin
                    push_end();
                end else if (ch == CH_D) begin
                    push_decimal(val);
                    dec_count++;
                end else if (ch == CH_B) begin
                    push_binary(val);
                    bin_count++;
                end
            end else if (ch == CH_NUL) begin
                push_end();
            end else if (ch == CH_PERCENT) begin
                escape_pending = 1'b1;
            end else begin
                push_char(ch);
            end
            // last flag goes on the final beat this input caused, if any
            if (expected_beats.size() > first) begin
                expected_beats[expected_beats.size() - 1].last = 1'b1;
            end
        endfunction

        // Called for every accepted result beat
        function void check_output_beat(result_beat_t got);
            result_beat_t want;
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: out_char %02h length %0d done_res %0b last %0b",
                       got.out_char, got.length, got.done_res, got.last);
                failures++;
                return;
            end
            want = expected_beats.pop_front();
            checked++;
            if (got.out_char !== want.out_char) begin
                $error("out_char: expected %02h, actual %02h", want.out_char, got.out_char);
                failures++;
            end
            if (got.length !== want.length) begin
                $error("length: expected %0d, actual %0d", want.length, got.length);
                failures++;
            end
            if (got.done_res !== want.done_res) begin
                $error("done_res: expected %0b, actual %0b", want.done_res, got.done_res);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic              aclk       = 1'b0;
    logic              aresetn    = 1'b0;
    logic              s_valid    = 1'b0;
    logic              s_ready;
    logic [CHAR_W-1:0] s_in_char  = '0;
    logic [VAL_W-1:0]  s_value    = '0;
    logic              m_valid;
    logic              m_ready    = 1'b0;
    logic [CHAR_W-1:0] m_out_char;
    logic [LEN_W-1:0]  m_length;
    logic              m_done_res;
    logic              m_last;

    expansion_checker checker_h;
    bit               steady     = 1'b0;
    int               beats_sent = 0;

    format_string_expander_unit #(
        .DEC_DIGITS (DEC_DIGITS),
        .BIN_BITS   (BIN_BITS)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_length   (m_length),
        .m_done_res (m_done_res),
        .m_last     (m_last)
    );

    always #4 aclk = ~aclk;

    // Idle cycles before the next beat; none during steady stretches
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    // Values for decimal escapes, biased toward short and boundary numbers
    function automatic bit [VAL_W-1:0] pick_value();
        unique case ($urandom_range(0, 3))
            0: return VAL_W'($urandom_range(0, 9));
            1: return VAL_W'($urandom_range(0, 999));
            2: return 16'hFFFF - VAL_W'($urandom_range(0, 9));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Send one beat; valid stays high between back-to-back beats
    task automatic send_beat(input bit [CHAR_W-1:0] ch, input bit [VAL_W-1:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_char <= ch;
        s_value   <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        checker_h.take_format_char(ch, val);
        beats_sent++;
    endtask

    task automatic send_escape(input bit [CHAR_W-1:0] sel, input bit [VAL_W-1:0] val);
        send_beat(CH_PERCENT, VAL_W'($urandom));
        send_beat(sel, val);
    endtask

    // Directed: field extremes, both escapes, unknown selectors, percent before NUL
    task automatic run_directed();
        send_beat(8'h41, 16'h0000);
        send_escape(CH_D, 16'h0000);
        send_escape(CH_D, 16'hFFFF);
        send_escape(CH_B, 16'hFFFF);
        send_escape(CH_B, 16'h0000);
        send_escape(CH_PERCENT, 16'h1234);
        send_escape(8'h7A, 16'h0001);
        send_beat(8'hFF, 16'hFFFF);
        send_beat(8'h01, 16'h0000);
        send_beat(CH_NUL, 16'h5555);
        send_escape(CH_D, 16'd10000);
        send_escape(CH_NUL, 16'hAAAA);
        send_beat(CH_NUL, 16'h0000);
        send_escape(CH_B, 16'hA5A5);
    endtask

    // One message: literals and escapes, mostly well formed, ended by NUL
    task automatic send_random_message();
        int  n_parts;
        int  kind;
        bit  long_bin;
        steady   = ($urandom_range(0, 3) == 0);
        long_bin = ($urandom_range(0, 9) == 0);
        n_parts  = long_bin ? $urandom_range(17, 20) : $urandom_range(1, 10);
        for (int i = 0; i < n_parts; i++) begin
            kind = long_bin ? 7 : $urandom_range(0, 9);
            if (kind <= 4) begin
                send_beat(CHAR_W'($urandom_range(1, 255)), VAL_W'($urandom));
            end else if (kind <= 6) begin
                send_escape(CH_D, pick_value());
            end else if (kind <= 8) begin
                send_escape(CH_B, VAL_W'($urandom));
            end else begin
                // unknown or arbitrary selector
                send_escape(CHAR_W'($urandom_range(0, 255)), VAL_W'($urandom));
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            send_beat(CH_PERCENT, VAL_W'($urandom));
        end
        send_beat(CH_NUL, VAL_W'($urandom));
    endtask

    // Result side: random ready gaps, check every accepted beat
    initial begin
        result_beat_t got;
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got = '{out_char: m_out_char, length: m_length,
                    done_res: m_done_res, last: m_last};
            checker_h.check_output_beat(got);
        end
    end

    // Main sequence
    initial begin
        checker_h = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        while (beats_sent < RANDOM_BEATS) begin
            send_random_message();
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        // drain, then idle before the final check
        while (checker_h.expected_beats.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (checker_h.expected_beats.size() != 0) begin
            $error("%0d result beats never arrived", checker_h.expected_beats.size());
            checker_h.failures++;
        end

        $display("Sent %0d input beats in %0d messages; checked %0d result beats.",
                 beats_sent, checker_h.msg_count, checker_h.checked);
        $display("Escapes: %0d decimal, %0d binary; length counter wrapped %0d times.",
                 checker_h.dec_count, checker_h.bin_count, checker_h.wrap_count);
        if (checker_h.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
